>>> src/texture_mip_claim_tracker_macros.svh
// ----------------------------------------------------------------------------
// Texture mip claim tracker assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_MIP_CLAIM_TRACKER_MACROS_SVH
`define TEXTURE_MIP_CLAIM_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset
`define TMCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included
`define TMCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define TMCT_ASSERT(label, prop, msg)
`define TMCT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/tmct_pkg.sv
// ----------------------------------------------------------------------------
// Texture mip claim tracker package
// Transaction types, operation codes and mark codes.
// ----------------------------------------------------------------------------
package tmct_pkg;

    // Operation codes
    localparam logic [2:0] OP_UPLOAD = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_BIND   = 3'd2;
    localparam logic [2:0] OP_WORLD  = 3'd3;
    localparam logic [2:0] OP_2D     = 3'd4;
    localparam logic [2:0] OP_CLAIM  = 3'd5;
    localparam logic [2:0] OP_RESET  = 3'd6;

    // Entry marks
    localparam logic [1:0] MARK_UNKNOWN   = 2'd0;
    localparam logic [1:0] MARK_CANDIDATE = 2'd1;
    localparam logic [1:0] MARK_OWNED     = 2'd2;
    localparam logic [1:0] MARK_GENERATED = 2'd3;

    localparam int MARK_W = 2;

    // Input transaction
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] texture_name;
        logic [4:0]  mip_level;
        logic [31:0] context_gen;
        logic        claim_enable;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic        claim_granted;
        logic [31:0] claimed_name;
    } out_t;

endpackage

>>> src/tmct_mark_ram.sv
// ----------------------------------------------------------------------------
// Texture mip claim tracker mark memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmct_mark_ram #(
    parameter int DEPTH = 16384
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  logic [tmct_pkg::MARK_W-1:0]        wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic [tmct_pkg::MARK_W-1:0]        rd_data
);

    logic [tmct_pkg::MARK_W-1:0] mem [DEPTH];
    logic [tmct_pkg::MARK_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/texture_mip_claim_tracker.sv
// ----------------------------------------------------------------------------
// Texture mip claim tracker
// Per-name 2-bit texture marks in a memory, plus binding and pass state.
//
//   channel | prefix | payload         | direction
//   --------+--------+-----------------+----------
//   input   | s_     | tmct_pkg::in_t  | in
//   result  | m_     | tmct_pkg::out_t | out
//
// Each transaction is accepted (a claim issues its memory read), then executes
// with the registered read data and loads the result register.
// A reset op, or a bind with a new context generation, starts a sweep that
// zeroes every entry of the mark memory; no input is taken meanwhile.
// After aresetn the same sweep runs before s_ready rises.
// A waiting result sits in the output register; execute stalls only if that
// register is still full when the next result is ready.
// ----------------------------------------------------------------------------
`include "texture_mip_claim_tracker_macros.svh"

module texture_mip_claim_tracker #(
    parameter int TABLE_DEPTH = 16384
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tmct_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tmct_pkg::out_t m_data
);

    localparam int          IDX_W     = $clog2(TABLE_DEPTH);
    localparam logic [31:0] DEPTH_W   = 32'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    tmct_pkg::in_t       item_reg;
    logic [31:0]         bound_name_reg;
    logic                world_reg;
    logic                since_reg;
    logic [31:0]         seen_gen_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic                m_valid_reg;
    tmct_pkg::out_t      m_data_reg;

    logic                accept;
    logic                slot_free;
    logic                exec_fire;
    logic                name_in;
    logic                bound_in;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [1:0]          rd_data;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [1:0]          ram_wdata;

    logic                op_wr_en;
    logic [IDX_W-1:0]    op_wr_addr;
    logic [1:0]          op_wr_data;
    logic                clear_req;
    logic [31:0]         bound_name_next;
    logic                world_next;
    logic                since_next;
    logic [31:0]         seen_gen_next;
    tmct_pkg::out_t      exec_out;

    // Handshake
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && slot_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Only a claim needs the stored mark; it looks at the bound name
    assign rd_en   = accept && (s_data.op == tmct_pkg::OP_CLAIM);
    assign rd_addr = bound_name_reg[IDX_W-1:0];

    assign name_in  = (item_reg.texture_name < DEPTH_W);
    assign bound_in = (bound_name_reg < DEPTH_W);

    // Operation decode and next state
    always_comb begin
        op_wr_en        = 1'b0;
        op_wr_addr      = item_reg.texture_name[IDX_W-1:0];
        op_wr_data      = tmct_pkg::MARK_UNKNOWN;
        clear_req       = 1'b0;
        bound_name_next = bound_name_reg;
        world_next      = world_reg;
        since_next      = since_reg;
        seen_gen_next   = seen_gen_reg;
        exec_out.claim_granted = 1'b0;
        unique case (item_reg.op)
            tmct_pkg::OP_UPLOAD: begin
                op_wr_en   = name_in;
                op_wr_data = (item_reg.mip_level == 5'd0) ? tmct_pkg::MARK_CANDIDATE
                                                          : tmct_pkg::MARK_OWNED;
            end
            tmct_pkg::OP_DELETE: begin
                op_wr_en   = name_in;
                op_wr_data = tmct_pkg::MARK_UNKNOWN;
            end
            tmct_pkg::OP_BIND: begin
                if (seen_gen_reg != item_reg.context_gen) begin
                    seen_gen_next = item_reg.context_gen;
                    clear_req     = 1'b1;
                end
                bound_name_next = item_reg.texture_name;
                since_next      = 1'b1;
            end
            tmct_pkg::OP_WORLD: begin
                world_next = 1'b1;
                since_next = 1'b0;
            end
            tmct_pkg::OP_2D: begin
                world_next = 1'b0;
                since_next = 1'b0;
            end
            tmct_pkg::OP_CLAIM: begin
                if (since_reg && item_reg.claim_enable && world_reg && bound_in &&
                    rd_data == tmct_pkg::MARK_CANDIDATE) begin
                    op_wr_en   = 1'b1;
                    op_wr_addr = bound_name_reg[IDX_W-1:0];
                    op_wr_data = tmct_pkg::MARK_GENERATED;
                    exec_out.claim_granted = 1'b1;
                end
            end
            tmct_pkg::OP_RESET: begin
                clear_req       = 1'b1;
                seen_gen_next   = item_reg.context_gen;
                bound_name_next = 32'd0;
                world_next      = 1'b0;
                since_next      = 1'b0;
            end
            default: begin
            end
        endcase
        exec_out.claimed_name = bound_name_next;
    end

    // Memory write: clear sweep or the executing operation
    assign ram_we    = (state_reg == ST_CLEAR) || (exec_fire && op_wr_en);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : op_wr_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? tmct_pkg::MARK_UNKNOWN : op_wr_data;

    tmct_mark_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer, tracker state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            bound_name_reg <= 32'd0;
            world_reg      <= 1'b0;
            since_reg      <= 1'b0;
            seen_gen_reg   <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_cnt_reg == LAST_IDX) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        item_reg  <= s_data;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (slot_free) begin
                        bound_name_reg <= bound_name_next;
                        world_reg      <= world_next;
                        since_reg      <= since_next;
                        seen_gen_reg   <= seen_gen_next;
                        clr_cnt_reg    <= '0;
                        state_reg      <= clear_req ? ST_CLEAR : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (exec_fire) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= exec_out;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Assertions
    `TMCT_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> state_reg == ST_CLEAR && clr_cnt_reg == '0, "reset must start the clear sweep")
    `TMCT_ASSERT(a_accept_exec, accept |=> state_reg == ST_EXEC, "accepted transaction must execute next")
    `TMCT_ASSERT(a_grant_src, exec_fire && exec_out.claim_granted |-> item_reg.op == tmct_pkg::OP_CLAIM && rd_data == tmct_pkg::MARK_CANDIDATE, "grant without candidate claim")
    `TMCT_ASSERT(a_clear_start, exec_fire && clear_req |=> state_reg == ST_CLEAR && clr_cnt_reg == '0, "clear request must restart the sweep")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture mip claim tracker testbench
// Drives upload, delete, bind, pass, claim and reset transactions through the
// valid/ready input channel. A local model of the mark table, binding and
// pass state predicts each result, and a checker compares every result
// transaction in order. Directed tests cover the claim rules, the table edges
// and the context clears. Random traffic follows, mostly upload/bind/claim
// sequences with noise mixed in. Both sides idle at random, and there is one
// long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import tmct_pkg::*;

    localparam int TABLE_DEPTH    = 16384;
    localparam int ITEM_TARGET    = 1450;
    localparam int MAX_CLEARS     = 20;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int REPORT_LIMIT   = 10;

    // Op code with no defined action
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Local copy of the tracker state
    bit [MARK_W-1:0] mark_table [TABLE_DEPTH];
    logic [31:0]     pred_bound      = '0;
    logic [31:0]     pred_seen_gen   = '0;
    bit              pred_world      = 1'b0;
    bit              pred_fresh_bind = 1'b0;

    out_t expected_results [$];

    int   cycle_count     = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   fault_count     = 0;
    int   grants_predicted = 0;
    int   table_clears    = 1;   // the sweep after aresetn
    bit [7:0] ops_seen    = '0;

    bit   tx_idle_on      = 1'b1;
    bit   rx_idle_on      = 1'b1;
    bit   rx_hold_request = 1'b0;
    int   rx_hold_left    = 0;
    int   rx_stall_left   = 0;

    texture_mip_claim_tracker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Names: a small hot pool, the whole table, its edges, and full 32-bit values
    function automatic logic [31:0] pick_name();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 32'($urandom_range(0, 31));
        if (r < 87) return 32'($urandom_range(0, TABLE_DEPTH - 1));
        if (r < 93) return ($urandom_range(0, 1) != 0) ? 32'(TABLE_DEPTH - 1) : 32'(TABLE_DEPTH);
        return $urandom();
    endfunction

    function automatic void wipe_marks();
        foreach (mark_table[i]) mark_table[i] = MARK_UNKNOWN;
        table_clears++;
    endfunction

    // Apply one transaction to the local state and return its result
    function automatic out_t predict_tracker(in_t it);
        out_t res;
        bit   in_range;
        res.claim_granted = 1'b0;
        in_range = it.texture_name < TABLE_DEPTH;
        ops_seen[it.op] = 1'b1;
        case (it.op)
            OP_UPLOAD: begin
                if (in_range)
                    mark_table[it.texture_name] = (it.mip_level == 0) ? MARK_CANDIDATE : MARK_OWNED;
            end
            OP_DELETE: begin
                if (in_range) mark_table[it.texture_name] = MARK_UNKNOWN;
            end
            OP_BIND: begin
                if (pred_seen_gen != it.context_gen) begin
                    pred_seen_gen = it.context_gen;
                    wipe_marks();
                end
                pred_bound      = it.texture_name;
                pred_fresh_bind = 1'b1;
            end
            OP_WORLD: begin
                pred_world      = 1'b1;
                pred_fresh_bind = 1'b0;
            end
            OP_2D: begin
                pred_world      = 1'b0;
                pred_fresh_bind = 1'b0;
            end
            OP_CLAIM: begin
                if (pred_fresh_bind && it.claim_enable && pred_world &&
                    pred_bound < TABLE_DEPTH && mark_table[pred_bound] == MARK_CANDIDATE) begin
                    mark_table[pred_bound] = MARK_GENERATED;
                    res.claim_granted = 1'b1;
                    grants_predicted++;
                end
            end
            OP_RESET: begin
                wipe_marks();
                pred_seen_gen   = it.context_gen;
                pred_bound      = '0;
                pred_world      = 1'b0;
                pred_fresh_bind = 1'b0;
            end
            default: ;
        endcase
        res.claimed_name = pred_bound;
        return res;
    endfunction

    // Bind keeps the current generation unless the caller changes it
    function automatic in_t tracker_item(logic [2:0] op, logic [31:0] name,
                                         logic [4:0] level, logic en);
        in_t it;
        it.op           = op;
        it.texture_name = name;
        it.mip_level    = level;
        it.claim_enable = en;
        it.context_gen  = (op == OP_BIND) ? pred_seen_gen : $urandom();
        return it;
    endfunction

    function automatic in_t random_item(logic [2:0] op);
        return tracker_item(op, pick_name(), 5'($urandom_range(0, 31)),
                            1'($urandom_range(0, 1)));
    endfunction

    // Any op; table clears only when allowed and within budget
    function automatic in_t random_noise_item(bit allow_clear);
        in_t it;
        bit  clear_ok;
        clear_ok = allow_clear && table_clears < MAX_CLEARS;
        it = random_item(3'($urandom_range(0, 7)));
        if (it.op == OP_RESET && !(clear_ok && $urandom_range(0, 3) == 0))
            it.op = OP_CLAIM;
        if (it.op == OP_BIND && clear_ok && $urandom_range(0, 29) == 0)
            it.context_gen = $urandom();
        return it;
    endfunction

    // Send one transaction, record its prediction, then idle a random gap if idling is on
    task automatic send_item(input in_t it);
        out_t want;
        int   gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_tracker(it);
        expected_results.push_back(want);
        items_sent++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] name,
                           input logic [4:0] level, input logic en);
        send_item(tracker_item(op, name, level, en));
    endtask

    // Sender pauses until every outstanding result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // Claim gating: enable, pass, fresh binding, candidate mark
    task automatic test_claim_rules();
        in_t it;
        it = tracker_item(OP_UNUSED, 32'hFFFF_FFFF, 5'h1F, 1'b1);
        it.context_gen = 32'hFFFF_FFFF;
        send_item(it);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        send_op(OP_WORLD,  32'd0, 5'd0, 1'b0);
        send_op(OP_UPLOAD, 32'd5, 5'd0, 1'b0);
        send_op(OP_BIND,   32'd5, 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        // base level uploaded again turns the generated entry back into a candidate
        send_op(OP_UPLOAD, 32'd5, 5'd0, 1'b0);
        send_op(OP_2D,     32'd0, 5'd0, 1'b0);
        send_op(OP_BIND,   32'd5, 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        send_op(OP_WORLD,  32'd0, 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
    endtask

    // First and last table entries, and names beyond the table
    task automatic test_table_edges();
        send_op(OP_BIND,   32'd0, 5'd0, 1'b0);
        send_op(OP_UPLOAD, 32'd0, 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        send_op(OP_UPLOAD, 32'(TABLE_DEPTH - 1), 5'h1F, 1'b0);
        send_op(OP_BIND,   32'(TABLE_DEPTH - 1), 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
        send_op(OP_UPLOAD, 32'hFFFF_FFFF, 5'd0, 1'b0);
        send_op(OP_DELETE, 32'(TABLE_DEPTH), 5'd0, 1'b0);
        send_op(OP_BIND,   32'(TABLE_DEPTH), 5'd0, 1'b0);
        send_op(OP_CLAIM,  32'd0, 5'd0, 1'b1);
    endtask

    // New generation on bind, then the reset op
    task automatic test_context_clear();
        in_t it;
        send_op(OP_UPLOAD, 32'd7, 5'd0, 1'b0);
        it = tracker_item(OP_BIND, 32'd7, 5'd0, 1'b0);
        it.context_gen = ~pred_seen_gen;
        send_item(it);
        send_op(OP_CLAIM, 32'd0, 5'd0, 1'b1);
        wait_results_drained();
        it = tracker_item(OP_RESET, 32'd0, 5'd0, 1'b0);
        it.context_gen = 32'hA5A5_5A5A;
        send_item(it);
        send_op(OP_CLAIM, 32'd0, 5'd0, 1'b1);
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        int k;
        tx_idle_on      = 1'b0;
        rx_hold_request = 1'b1;
        for (k = 0; k < 40; k++) send_item(random_noise_item(1'b0));
        tx_idle_on = 1'b1;
    endtask

    // Upload, bind and claim on one name, with random content around it
    task automatic send_claim_sequence();
        logic [31:0] name;
        in_t         it;
        name = pick_name();
        if ($urandom_range(0, 4) != 0)
            send_item(random_item(($urandom_range(0, 5) != 0) ? OP_WORLD : OP_2D));
        it = random_item(OP_UPLOAD);
        it.texture_name = name;
        it.mip_level = ($urandom_range(0, 9) < 7) ? 5'd0 : 5'($urandom_range(1, 31));
        send_item(it);
        if ($urandom_range(0, 5) == 0) send_item(random_noise_item(1'b1));
        it = random_item(OP_BIND);
        it.texture_name = name;
        if (table_clears < MAX_CLEARS && $urandom_range(0, 29) == 0)
            it.context_gen = $urandom();
        send_item(it);
        it = random_item(OP_CLAIM);
        it.claim_enable = ($urandom_range(0, 7) != 0);
        send_item(it);
        if ($urandom_range(0, 2) == 0) send_item(random_item(OP_CLAIM));
        if ($urandom_range(0, 3) == 0) begin
            it = random_item(($urandom_range(0, 1) != 0) ? OP_DELETE : OP_UPLOAD);
            it.texture_name = name;
            send_item(it);
        end
    endtask

    // Bulk random traffic in stretches with and without idling
    task automatic test_random_traffic();
        int stretch_end;
        while (items_sent < ITEM_TARGET) begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            stretch_end = items_sent + $urandom_range(30, 90);
            while (items_sent < stretch_end) begin
                if ($urandom_range(0, 9) < 7) send_claim_sequence();
                else send_item(random_noise_item(1'b1));
            end
            if ($urandom_range(0, 3) == 0) wait_results_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result receiver: random stalls plus the requested long hold
    always @(posedge aclk) begin
        if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rx_hold_left    = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_on) rx_stall_left = pick_gap();
        end
    end

    task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("Mismatch: %s expected %h actual %h", what, want, got);
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                note_fault("unexpected result, claimed_name", 32'bx, m_data.claimed_name);
            end else begin
                want = expected_results.pop_front();
                if (m_data.claim_granted !== want.claim_granted)
                    note_fault("claim_granted", 32'(want.claim_granted), 32'(m_data.claim_granted));
                if (m_data.claimed_name !== want.claimed_name)
                    note_fault("claimed_name", want.claimed_name, m_data.claimed_name);
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("FAIL texture_mip_claim_tracker");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_claim_rules();
        test_table_edges();
        test_context_clear();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            fault_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("Sent %0d transactions, checked %0d results in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("Claims granted %0d, table clears %0d, op codes seen %b, faults %0d",
                 grants_predicted, table_clears, ops_seen, fault_count);
        if (fault_count == 0) begin
            $display("PASS texture_mip_claim_tracker");
        end else begin
            $display("FAIL texture_mip_claim_tracker");
        end
        $finish;
    end

endmodule
